>>> sv/sntp_offset_bound_estimator_macros.svh
// ---------------------------------------------------------------------------
// SNTP offset bound estimator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef SNTP_OFFSET_BOUND_ESTIMATOR_MACROS_SVH
`define SNTP_OFFSET_BOUND_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SOBE_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sobe assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SOBE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sobe assertion failed");

`endif

>>> sv/sobe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SNTP offset bound estimator package
// Types and constants shared by the estimator modules.
// ---------------------------------------------------------------------------
package sobe_pkg;

   localparam int unsigned TIME_W   = 64;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_IDX_W = 8;

   // Offset bias in whole seconds; shifted into the 32.32 integer part.
   localparam logic [31:0] BIAS_SECONDS = 32'd1072224000;
   localparam logic [TIME_W-1:0] SNTP_BIAS   = {BIAS_SECONDS, 32'h0};
   localparam logic [TIME_W-1:0] UPPER_RESET = {BIAS_SECONDS[30:0], 33'h0};
   localparam logic [TIME_W-1:0] ERR_LIMIT_RESET = 64'd429496730;

   localparam logic [7:0] VERSION_MASK = 8'd56;
   localparam logic [7:0] MODE_MASK    = 8'd7;
   localparam logic [7:0] MODE_SYM_PASSIVE = 8'd2;
   localparam logic [7:0] MODE_SERVER      = 8'd4;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FORCED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ERR_LIMIT    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_OUTPUT = 8'd1;

   // State-independent terms of one transaction, held in the input register.
   typedef struct packed {
      logic              finish;
      logic              reply_ok;
      logic [TIME_W:0]   rx_sum;
      logic [TIME_W:0]   tx_sum;
      logic [TIME_W-1:0] t_send;
      logic [TIME_W-1:0] t_recv;
      logic [TIME_W-1:0] up_cand;
      logic [TIME_W-1:0] lo_cand;
      logic [TIME_W:0]   recv_up;
   } sobe_prep_type;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [TIME_W-1:0]    data;
   } sobe_csr_type;

endpackage

>>> sv/sobe_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SNTP offset bound estimator input stage
// Validates the reply and forms the bias-adjusted sums and bound candidates,
// then registers them.
// ---------------------------------------------------------------------------
module sobe_prep
   import sobe_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic              req_type,
   input  logic [TIME_W-1:0] t_send,
   input  logic [TIME_W-1:0] t_server_rx,
   input  logic [TIME_W-1:0] t_server_tx,
   input  logic [TIME_W-1:0] t_recv,
   input  logic [7:0]        header_byte,
   input  logic [TIME_W-1:0] echoed_origin,
   output sobe_prep_type     prep_ff
);

   sobe_prep_type prep_in;
   logic [7:0]    mode;

   always_comb begin
      mode             = header_byte & MODE_MASK;
      prep_in.finish   = req_type;
      prep_in.reply_ok = (mode inside {MODE_SYM_PASSIVE, MODE_SERVER}) &&
                         ((header_byte & VERSION_MASK) != 8'd0) &&
                         (echoed_origin == t_send);
      prep_in.rx_sum   = {1'b0, t_server_rx} + {1'b0, SNTP_BIAS};
      prep_in.tx_sum   = {1'b0, t_server_tx} + {1'b0, SNTP_BIAS};
      prep_in.t_send   = t_send;
      prep_in.t_recv   = t_recv;
      prep_in.up_cand  = prep_in.rx_sum[TIME_W-1:0] - t_send;
      prep_in.lo_cand  = prep_in.tx_sum[TIME_W-1:0] - t_recv;
      // Receive time plus the upper bound as it would be after this reply.
      prep_in.recv_up  = {1'b0, t_recv} + {1'b0, prep_in.up_cand};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prep_ff <= prep_in;
      end
   end

endmodule

>>> sv/sobe_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SNTP offset bound estimator core
// Holds the bracket, the success count and the configuration, narrows the
// bracket per exchange and forms the report on finish.
// ---------------------------------------------------------------------------
module sobe_core
   import sobe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  sobe_prep_type       prep,
   input  sobe_csr_type        csr,
   output logic [STATUS_W-1:0] status_ff,
   output logic [TIME_W-1:0]   offset_ff,
   output logic [TIME_W-1:0]   spread_ff,
   output logic [COUNT_W-1:0]  total_ff
);

   logic [TIME_W-1:0]  lower_ff, lower_in;
   logic [TIME_W-1:0]  upper_ff, upper_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  err_limit_ff;
   logic               force_ff;

   logic [STATUS_W-1:0] status_in;
   logic [TIME_W-1:0]   offset_in;
   logic [TIME_W-1:0]   spread_in;
   logic [COUNT_W-1:0]  total_in;

   logic [TIME_W:0]    send_lo, send_hi, recv_lo, recv_hi;
   logic               rx_hit, tx_hit;
   logic [TIME_W-1:0]  upper_new, lower_new;
   logic [COUNT_W-1:0] count_inc;
   logic [TIME_W-1:0]  spread;
   logic [TIME_W:0]    bound_sum;
   logic [TIME_W-1:0]  midpoint;

   always_comb begin
      send_lo = {1'b0, prep.t_send} + {1'b0, lower_ff};
      send_hi = {1'b0, prep.t_send} + {1'b0, upper_ff};
      rx_hit  = (prep.rx_sum < send_hi) && !(prep.rx_sum < send_lo);
      upper_new = rx_hit ? prep.up_cand : upper_ff;

      // The transmit-side window uses the upper bound after the receive test.
      recv_lo = {1'b0, prep.t_recv} + {1'b0, lower_ff};
      recv_hi = rx_hit ? prep.recv_up : ({1'b0, prep.t_recv} + {1'b0, upper_ff});
      tx_hit  = (prep.tx_sum < recv_hi) && !(prep.tx_sum < recv_lo);
      lower_new = tx_hit ? prep.lo_cand : lower_ff;

      count_inc = (count_ff == {COUNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;

      spread    = (upper_ff < lower_ff) ? lower_ff - upper_ff : upper_ff - lower_ff;
      bound_sum = {1'b0, upper_ff} + {1'b0, lower_ff};
      midpoint  = bound_sum[TIME_W:1];

      lower_in  = lower_ff;
      upper_in  = upper_ff;
      count_in  = count_ff;
      status_in = ST_REJECTED;
      offset_in = '0;
      spread_in = '0;
      total_in  = count_ff;

      if (prep.finish) begin
         lower_in = '0;
         upper_in = UPPER_RESET;
         count_in = '0;
         if (count_ff == '0) begin
            status_in = ST_NONE;
         end else begin
            spread_in = spread;
            if (spread > err_limit_ff) begin
               if (force_ff) begin
                  status_in = ST_FORCED;
                  offset_in = midpoint - SNTP_BIAS;
               end else begin
                  status_in = ST_REFUSED;
               end
            end else begin
               status_in = ST_OK;
               offset_in = midpoint - SNTP_BIAS;
            end
         end
      end else if (prep.reply_ok) begin
         lower_in  = lower_new;
         upper_in  = upper_new;
         count_in  = count_inc;
         status_in = ST_ACCEPTED;
         total_in  = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff     <= '0;
         upper_ff     <= UPPER_RESET;
         count_ff     <= '0;
         err_limit_ff <= ERR_LIMIT_RESET;
         force_ff     <= 1'b0;
      end else begin
         if (fire) begin
            lower_ff <= lower_in;
            upper_ff <= upper_in;
            count_ff <= count_in;
         end
         if (csr.we) begin
            case (csr.index)
               CSR_ERR_LIMIT:    err_limit_ff <= csr.data;
               CSR_FORCE_OUTPUT: force_ff     <= csr.data[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
         spread_ff <= spread_in;
         total_ff  <= total_in;
      end
   end

endmodule

>>> sv/sntp_offset_bound_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SNTP offset bound estimator
// Narrows a bracket around the clock offset from SNTP exchanges and reports
// the offset estimate and its uncertainty when a series is finished.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless a result stalls on
// rsp_tready, and returns exactly one result transaction for each once the
// result side is ready. The input register holds the reply check and the
// bias-adjusted sums; the core then updates the bracket registers and loads
// the result register, and the bracket state feeding its own update with no
// further register is what sets the rate. A stalled result still lets a
// request into the input register if it is empty. Configuration writes are
// always taken (csr_ready is tied high) and should only be issued while idle.
// ---------------------------------------------------------------------------
module sntp_offset_bound_estimator
   import sobe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // t_send[63:0], t_server_rx[127:64], t_server_tx[191:128], t_recv[255:192],
   // header_byte[263:256], echoed_origin[327:264]
   input  logic [327:0] req_tdata,
   // req_type[0]
   input  logic [0:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // offset_estimate[63:0] (signed), uncertainty[127:64], success_total[135:128]
   output logic [135:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data
);

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance, load, fire;

   sobe_prep_type       prep;
   sobe_csr_type        csr;
   logic [STATUS_W-1:0] status;
   logic [TIME_W-1:0]   offset;
   logic [TIME_W-1:0]   spread;
   logic [COUNT_W-1:0]  total;

   always_comb begin
      advance      = !rsp_valid_ff || rsp_tready;
      req_tready   = !s1_valid_ff || advance;
      load         = req_tvalid && req_tready;
      fire         = s1_valid_ff && advance;
      s1_valid_in  = load ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      csr.we       = csr_valid;
      csr.index    = csr_index;
      csr.data     = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   sobe_prep u_prep (
      .clock         (clock),
      .load          (load),
      .req_type      (req_tuser[0]),
      .t_send        (req_tdata[63:0]),
      .t_server_rx   (req_tdata[127:64]),
      .t_server_tx   (req_tdata[191:128]),
      .t_recv        (req_tdata[255:192]),
      .header_byte   (req_tdata[263:256]),
      .echoed_origin (req_tdata[327:264]),
      .prep_ff       (prep)
   );

   sobe_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .prep      (prep),
      .csr       (csr),
      .status_ff (status),
      .offset_ff (offset),
      .spread_ff (spread),
      .total_ff  (total)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status;
   assign rsp_tdata  = {total, spread, offset};

endmodule

>>> sv/sobe_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SNTP offset bound estimator port checker
// Watches the result channel for held transactions and consistent reports.
// ---------------------------------------------------------------------------
`include "sntp_offset_bound_estimator_macros.svh"

module sobe_checker
   import sobe_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   logic         rsp_stall;
   logic [138:0] rsp_word;
   logic         exch_rsp;
   logic         exch_clean;
   logic         none_rsp;
   logic         refused_rsp;
   logic         refused_clean;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign exch_rsp    = rsp_tvalid && (rsp_tuser inside {ST_ACCEPTED, ST_REJECTED});
   assign exch_clean  = (rsp_tdata[127:0] == 128'd0) &&
                        ((rsp_tuser != ST_ACCEPTED) || (rsp_tdata[135:128] != 8'd0));
   assign none_rsp    = rsp_tvalid && (rsp_tuser == ST_NONE);
   assign refused_rsp = rsp_tvalid && (rsp_tuser == ST_REFUSED);
   assign refused_clean = (rsp_tdata[63:0] == 64'd0) && (rsp_tdata[127:64] != 64'd0) &&
                          (rsp_tdata[135:128] != 8'd0);

   // A stalled result transaction keeps its contents.
   `SOBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // Exchange results carry no estimate; an accepted one has a nonzero count.
   `SOBE_ASSERT_IMPL(a_exchange_zero, clock, reset, exch_rsp, exch_clean)

   // A finish without successes reports nothing and a zero count.
   `SOBE_ASSERT_IMPL(a_none_empty, clock, reset, none_rsp, rsp_tdata == 136'd0)

   // A refused estimate has a zero offset, a nonzero spread and a nonzero count.
   `SOBE_ASSERT_IMPL(a_refused, clock, reset, refused_rsp, refused_clean)

endmodule

bind sntp_offset_bound_estimator sobe_checker u_sobe_checker (.*);

>>> tb/sntp_offset_bound_estimator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SNTP offset bound estimator testbench
// Drives exchange and finish transactions through the request stream, keeps
// its own bracket model of the estimator and compares every result
// transaction field by field, across several error limits, force settings
// and idle patterns on both stream sides.
// ---------------------------------------------------------------------------
module sntp_offset_bound_estimator_tb;
   import sobe_pkg::*;

   localparam logic REQ_EXCHANGE = 1'b0;
   localparam logic REQ_FINISH   = 1'b1;

   // Mode values that a reply must not carry.
   localparam logic [2:0] MODE_RESERVED = 3'd0;
   localparam logic [2:0] MODE_CLIENT   = 3'd3;
   localparam logic [2:0] MODE_PRIVATE  = 3'd7;

   // Register indexes that decode to nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP   = 8'hFF;

   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 244;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [TIME_W-1:0] offset;
      logic [TIME_W-1:0]        spread;
      logic [COUNT_W-1:0]       total;
   } estimate_type;

   class offset_bracket_scoreboard;
      logic [TIME_W-1:0]  err_limit;
      logic               force_out;
      logic [TIME_W-1:0]  lower_b;
      logic [TIME_W-1:0]  upper_b;
      logic [COUNT_W-1:0] accepted;
      estimate_type       want_q[$];
      int                 errors;
      int                 checked;
      int                 status_hits[8];

      function new();
         err_limit = ERR_LIMIT_RESET;
         force_out = 1'b0;
         errors    = 0;
         checked   = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
         restart_series();
      endfunction

      function void restart_series();
         lower_b  = '0;
         upper_b  = UPPER_RESET;
         accepted = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
         if (idx == CSR_ERR_LIMIT) err_limit = val;
         else if (idx == CSR_FORCE_OUTPUT) force_out = val[0];
      endfunction

      function logic [TIME_W-1:0] current_spread();
         return (upper_b < lower_b) ? lower_b - upper_b : upper_b - lower_b;
      endfunction

      function int pending();
         return want_q.size();
      endfunction

      // Works out the result of one accepted request transaction.
      function void note_request(logic finish, logic [327:0] data);
         logic [TIME_W-1:0] t_send, t_rx, t_tx, t_recv, echo;
         logic [7:0]        hdr, mode;
         logic [TIME_W:0]   cand, lo_edge, hi_edge, mid_sum;
         estimate_type      e;
         t_send   = data[63:0];
         t_rx     = data[127:64];
         t_tx     = data[191:128];
         t_recv   = data[255:192];
         hdr      = data[263:256];
         echo     = data[327:264];
         e.offset = '0;
         e.spread = '0;
         if (finish == REQ_EXCHANGE) begin
            mode = hdr & MODE_MASK;
            if ((mode == MODE_SYM_PASSIVE || mode == MODE_SERVER) &&
                (hdr & VERSION_MASK) != '0 && echo == t_send) begin
               cand    = {1'b0, t_rx} + {1'b0, SNTP_BIAS};
               lo_edge = {1'b0, t_send} + {1'b0, lower_b};
               hi_edge = {1'b0, t_send} + {1'b0, upper_b};
               if (cand >= lo_edge && cand < hi_edge) upper_b = cand[TIME_W-1:0] - t_send;
               // The lower test already sees the narrowed upper bound.
               cand    = {1'b0, t_tx} + {1'b0, SNTP_BIAS};
               lo_edge = {1'b0, t_recv} + {1'b0, lower_b};
               hi_edge = {1'b0, t_recv} + {1'b0, upper_b};
               if (cand >= lo_edge && cand < hi_edge) lower_b = cand[TIME_W-1:0] - t_recv;
               if (accepted != '1) accepted++;
               e.status = ST_ACCEPTED;
            end else begin
               e.status = ST_REJECTED;
            end
            e.total = accepted;
         end else begin
            e.total = accepted;
            if (accepted == '0) begin
               e.status = ST_NONE;
            end else begin
               e.spread = current_spread();
               mid_sum  = {1'b0, upper_b} + {1'b0, lower_b};
               e.offset = mid_sum[TIME_W:1] - SNTP_BIAS;
               if (e.spread > err_limit) begin
                  if (force_out) begin
                     e.status = ST_FORCED;
                  end else begin
                     e.status = ST_REFUSED;
                     e.offset = '0;
                  end
               end else begin
                  e.status = ST_OK;
               end
            end
            restart_series();
         end
         want_q.push_back(e);
      endfunction

      task report(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
         $display("result %0d: %s is %h, expected %h", checked, what, got, want);
         errors++;
      endtask

      task check_result(logic [STATUS_W-1:0] st, logic [135:0] data);
         estimate_type e;
         checked++;
         if (want_q.size() == 0) begin
            report("result with nothing outstanding, status", st, '0);
            return;
         end
         e = want_q.pop_front();
         status_hits[e.status]++;
         if (st !== e.status) report("status", st, e.status);
         if (data[63:0] !== e.offset) report("offset_estimate", data[63:0], e.offset);
         if (data[127:64] !== e.spread) report("uncertainty", data[127:64], e.spread);
         if (data[135:128] !== e.total) report("success_total", data[135:128], e.total);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [327:0]         req_tdata = '0;
   logic [0:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [135:0]         rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_data = '0;

   offset_bracket_scoreboard sb;
   int snd_idle_pct  = 0;
   int rcv_stall_pct = 0;
   int items_sent    = 0;
   int series_count  = 0;
   int reg_settings  = 0;

   sntp_offset_bound_estimator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   function automatic logic [TIME_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [327:0] random_bits();
      logic [327:0] v;
      v = '0;
      for (int i = 0; i < 11; i++) v = {v[295:0], $urandom};
      return v;
   endfunction

   function automatic logic [327:0] pack_req(logic [TIME_W-1:0] t_send, t_rx, t_tx, t_recv,
                                             logic [7:0] hdr, logic [TIME_W-1:0] echo);
      return {echo, hdr, t_recv, t_tx, t_rx, t_send};
   endfunction

   function automatic logic [7:0] make_header(logic [1:0] leap, logic [2:0] ver,
                                              logic [2:0] mode);
      return {leap, ver, mode};
   endfunction

   function automatic logic [7:0] good_header();
      logic [7:0] mode;
      mode = $urandom_range(1) ? MODE_SERVER : MODE_SYM_PASSIVE;
      return make_header(2'($urandom), 3'($urandom_range(1, 7)), mode[2:0]);
   endfunction

   // Send times leave room for the bias and the delays on either side, so
   // that realistic replies do not wrap around the 64-bit range.
   function automatic logic [TIME_W-1:0] plain_send_time();
      return {32'($urandom_range(32'd1072224001, 32'd3222742000)), $urandom};
   endfunction

   function automatic logic [TIME_W-1:0] rand_delay(int scale);
      case (scale)
         0: return 64'($urandom_range(0, 32'h0040_0000));
         1: return 64'($urandom_range(0, 32'h4000_0000));
         default: return {26'd0, 6'($urandom), $urandom};
      endcase
   endfunction

   task automatic send_item(input logic finish, input logic [327:0] data);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= finish;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sb.note_request(finish, data);
      items_sent++;
   endtask

   // offb is the true offset plus the bias; the reply brackets it by the
   // forward and backward path delays.
   task automatic run_exchange(input logic [TIME_W-1:0] t_send, offb, d_fwd, d_srv, d_back,
                               input logic [7:0] hdr, input logic [TIME_W-1:0] echo);
      logic [TIME_W-1:0] t_rx, t_tx, t_recv;
      t_rx   = t_send + offb - SNTP_BIAS + d_fwd;
      t_tx   = t_rx + d_srv;
      t_recv = t_send + d_fwd + d_srv + d_back;
      send_item(REQ_EXCHANGE, pack_req(t_send, t_rx, t_tx, t_recv, hdr, echo));
   endtask

   task automatic finish_series();
      send_item(REQ_FINISH, random_bits());
      series_count++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   // Only called with no transaction in flight.
   task automatic program_regs(input logic [TIME_W-1:0] limit, input logic force_on);
      csr_write(CSR_ERR_LIMIT, limit);
      csr_write(CSR_FORCE_OUTPUT, {63'(rand64()), force_on});
      csr_write(CSR_IDX_W'($urandom_range(CSR_IDX_SPARE, CSR_IDX_TOP)), rand64());
      csr_valid <= 1'b0;
      reg_settings++;
   endtask

   task automatic tight_series(input logic [TIME_W-1:0] offb);
      logic [TIME_W-1:0] t_send;
      t_send = 64'hA000_0000_1234_5678;
      run_exchange(t_send, offb, 64'h0100_0000, 64'h0010_0000, 64'h0200_0000,
                   make_header(2'd0, 3'd4, MODE_SERVER[2:0]), t_send);
      run_exchange(t_send + 64'h1_0000_0000, offb, 64'h0080_0000, 64'h0001_0000,
                   64'h0100_0000, make_header(2'd1, 3'd3, MODE_SYM_PASSIVE[2:0]),
                   t_send + 64'h1_0000_0000);
      // Both candidates fall outside the narrowed bracket.
      run_exchange(t_send + 64'h2_0000_0000, offb, 64'h0400_0000, 64'h0002_0000,
                   64'h0400_0000, make_header(2'd0, 3'd4, MODE_SERVER[2:0]),
                   t_send + 64'h2_0000_0000);
   endtask

   task automatic random_series(input int len);
      logic [TIME_W-1:0] offb, t_send, echo;
      logic [7:0]        hdr;
      int                scale, pick;
      offb  = {32'($urandom_range(0, 32'd2144447999)), $urandom};
      scale = $urandom_range(2);
      repeat (len) begin
         pick   = $urandom_range(99);
         t_send = ($urandom_range(99) < 88) ? plain_send_time() : rand64();
         hdr    = good_header();
         echo   = t_send;
         if (pick < 72) begin
            run_exchange(t_send, offb, rand_delay(scale), rand_delay(0), rand_delay(scale),
                         hdr, echo);
         end else if (pick < 86) begin
            case ($urandom_range(2))
               0: begin
                  hdr[2:0] = 3'($urandom);
                  while (hdr[2:0] == MODE_SERVER[2:0] || hdr[2:0] == MODE_SYM_PASSIVE[2:0])
                     hdr[2:0] = 3'($urandom);
               end
               1: hdr[5:3] = '0;
               default: echo = t_send ^ (64'd1 << $urandom_range(63));
            endcase
            run_exchange(t_send, offb, rand_delay(scale), rand_delay(0), rand_delay(scale),
                         hdr, echo);
         end else begin
            send_item(REQ_EXCHANGE, pack_req(t_send, rand64(), rand64(), rand64(),
                                             8'($urandom),
                                             $urandom_range(1) ? t_send : rand64()));
         end
      end
      finish_series();
   endtask

   initial begin
      logic [TIME_W-1:0] limit, offb;
      logic              force_on;
      int                phase_start;
      bit                paused, long_done;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every status, header rejections and extreme times.
      finish_series();
      send_item(REQ_EXCHANGE, pack_req('0, '0, '0, '0,
                                       make_header(2'd0, 3'd1, MODE_SERVER[2:0]), '0));
      send_item(REQ_EXCHANGE, pack_req('1, '1, '1, '1,
                                       make_header(2'd3, 3'd7, MODE_SERVER[2:0]), '1));
      offb = SNTP_BIAS + 64'h0000_0002_8000_0000;
      run_exchange(64'hA000_0000_0000_0000, offb, 64'h100, 64'h10, 64'h100,
                   make_header(2'd2, 3'd3, MODE_CLIENT), 64'hA000_0000_0000_0000);
      run_exchange(64'hA000_0000_0000_0000, offb, 64'h100, 64'h10, 64'h100,
                   make_header(2'd0, 3'd0, MODE_SERVER[2:0]), 64'hA000_0000_0000_0000);
      run_exchange(64'hA000_0000_0000_0000, offb, 64'h100, 64'h10, 64'h100,
                   make_header(2'd0, 3'd4, MODE_SERVER[2:0]), 64'hA000_0000_0000_0001);
      run_exchange(64'hA000_0000_0000_0000, offb, 64'h100, 64'h10, 64'h100,
                   make_header(2'd3, 3'd7, MODE_PRIVATE), 64'hA000_0000_0000_0000);
      run_exchange(64'hA000_0000_0000_0000, offb, 64'h100, 64'h10, 64'h100,
                   make_header(2'd0, 3'd2, MODE_RESERVED), 64'hA000_0000_0000_0000);
      finish_series();

      // A spread equal to the limit passes; one more than the limit does not.
      tight_series(offb);
      drain_results();
      program_regs(sb.current_spread(), 1'b0);
      finish_series();
      tight_series(SNTP_BIAS - 64'h0000_0001_4000_0000);
      drain_results();
      program_regs(sb.current_spread() - 64'd1, 1'b1);
      finish_series();

      long_done = 0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         case (phase)
            0: begin limit = ERR_LIMIT_RESET; force_on = 1'b0; end
            1: begin limit = '0; force_on = 1'b1; end
            2: begin limit = '1; force_on = 1'b0; end
            3: begin limit = 64'($urandom_range(32'h0010_0000, 32'h4000_0000)); force_on = 1'b1; end
            4: begin limit = 64'h0100_0000; force_on = 1'b0; end
            5: begin limit = rand64(); force_on = 1'b1; end
            6: begin limit = '0; force_on = 1'b0; end
            default: begin limit = ERR_LIMIT_RESET; force_on = 1'b1; end
         endcase
         program_regs(limit, force_on);
         snd_idle_pct  = (phase % 4 == 1) ? 65 : (phase % 4 == 3) ? 6 : 0;
         rcv_stall_pct = (phase % 4 == 2) ? 65 : (phase % 4 == 3) ? 6 : 0;
         phase_start = items_sent;
         paused      = 0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (phase == 5 && !long_done) begin
               // A series of more items than the 8-bit success count can hold.
               random_series(270);
               long_done = 1;
            end else begin
               random_series($urandom_range(0, 10));
            end
            if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1;
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Sent %0d transactions in %0d series under %0d register settings.",
               items_sent, series_count, reg_settings);
      $display("Results: %0d accepted, %0d rejected, %0d ok, %0d forced, %0d refused, %0d empty.",
               sb.status_hits[ST_ACCEPTED], sb.status_hits[ST_REJECTED],
               sb.status_hits[ST_OK], sb.status_hits[ST_FORCED],
               sb.status_hits[ST_REFUSED], sb.status_hits[ST_NONE]);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/sobe_pkg.sv
sv/sobe_prep.sv
sv/sobe_core.sv
sv/sntp_offset_bound_estimator.sv
sv/sobe_checker.sv
tb/sntp_offset_bound_estimator_tb.sv
